/* hw/rtl/tkds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tkds_pkg;

	localparam int MAX_KEEP = 16;
	localparam int ID_W     = 24;
	localparam int DEG_W    = 24;
	localparam int LIM_W    = 5;
	localparam int CNT_W    = $clog2(MAX_KEEP + 1);
	localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int DATA_W   = ID_W + DEG_W;

	localparam logic [LIM_W-1:0] TOP_COUNT_RESET = LIM_W'(16);

	typedef struct packed {
		logic take;       // latch the offered item
		logic append;     // store the item at the next free slot
		logic min_clear;  // start a search for the smallest held pair
		logic min_step;   // examine one entry in the smallest-pair search
		logic replace;    // overwrite the smallest pair if the item beats it
		logic max_clear;  // start a search for the largest unsent pair
		logic max_step;   // examine one entry in the largest-pair search
		logic load_out;   // move the largest unsent pair to the output register
		logic clear_all;  // empty the store after the final result
	} tkds_cmd_t;

	typedef struct packed {
		logic full;       // held count has reached the effective limit
		logic min_ok;     // cached smallest pair is current
		logic scan_last;  // scan index points at the last held entry
		logic item_last;  // latched item carries the last marker
		logic out_free;   // output register can take a new result
		logic emit_last;  // next result to load is the final one
	} tkds_stat_t;

	// Effective limit: zero acts as one, anything above capacity acts as capacity.
	function automatic logic [CNT_W-1:0] eff_limit(input logic [LIM_W-1:0] top_count);
		logic [CNT_W-1:0] lim;
		if (top_count == '0) begin
			lim = CNT_W'(1);
		end else if (int'(top_count) > MAX_KEEP) begin
			lim = CNT_W'(MAX_KEEP);
		end else begin
			lim = CNT_W'(top_count);
		end
		return lim;
	endfunction

	// True when pair a ranks below pair b in (degree, id) order.
	function automatic logic ranks_below(input logic [DEG_W-1:0] da, input logic [ID_W-1:0] ia,
			input logic [DEG_W-1:0] db, input logic [ID_W-1:0] ib);
		logic r;
		if (da != db) begin
			r = (da < db);
		end else begin
			r = (ia < ib);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/top_k_degree_select.sv */
// Top-k degree selection over a stream of (vertex id, degree) pairs.
// Input channel s_axis: one transaction per vertex, tlast on the final one.
// Output channel m_axis: on the final vertex the held pairs come out in
// descending (degree, id) order, tlast on the last of them.
// cfg_wr_en/cfg_wr_data write top_count (0 acts as 1, above capacity acts
// as capacity); write it only while the block is idle.
// Throughput: a pair passes an accept state and then a decide state while
// the store fills or while the cached smallest pair is current. Once the
// store is full and the cache is stale (after it fills or after a
// replacement), the next pair first rescans the held entries for the
// smallest one. A new pair is accepted only after the last one is decided.
// Emission: each result takes a start state, a scan of all held pairs and a
// load state; the single read port of the register store makes the scan
// visit one pair at a time. No input is taken during emission.
// The output register lets a result wait for the receiver while the block
// accepts the next input; a stalled receiver holds emission in place.
// Reset empties the store, clears the output and sets top_count to 16.
`timescale 1ns / 1ps
`default_nettype none

module top_k_degree_select (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [tkds_pkg::DATA_W-1:0]   s_axis_tdata,  // vertex_id, degree
	input  wire logic                          s_axis_tlast,  // last_in
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [tkds_pkg::DATA_W-1:0]        m_axis_tdata,  // kept_id, kept_degree
	output logic                               m_axis_tlast,  // last_out
	input  wire logic                          cfg_wr_en,
	input  wire logic [tkds_pkg::LIM_W-1:0]    cfg_wr_data    // top_count
);
	import tkds_pkg::*;

	tkds_cmd_t        cmd;
	tkds_stat_t       stat;
	logic [LIM_W-1:0] top_count_q;
	logic [ID_W-1:0]  out_id;
	logic [DEG_W-1:0] out_deg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= TOP_COUNT_RESET;
		end else if (cfg_wr_en) begin
			top_count_q <= cfg_wr_data;
		end
	end

	tkds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tkds_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.top_count (top_count_q),
		.in_id     (s_axis_tdata[ID_W-1:0]),
		.in_deg    (s_axis_tdata[DATA_W-1:ID_W]),
		.in_last   (s_axis_tlast),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_id    (out_id),
		.out_deg   (out_deg),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_deg, out_id};

endmodule

`default_nettype wire

/* hw/rtl/tkds_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tkds_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tkds_pkg::tkds_cmd_t         cmd,
	output tkds_pkg::tkds_stat_t             stat,
	input  wire logic [tkds_pkg::LIM_W-1:0]  top_count,
	input  wire logic [tkds_pkg::ID_W-1:0]   in_id,
	input  wire logic [tkds_pkg::DEG_W-1:0]  in_deg,
	input  wire logic                        in_last,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [tkds_pkg::ID_W-1:0]        out_id,
	output logic [tkds_pkg::DEG_W-1:0]       out_deg,
	output logic                             out_last
);
	import tkds_pkg::*;

	logic [DEG_W-1:0] held_deg_q [MAX_KEEP];
	logic [ID_W-1:0]  held_id_q  [MAX_KEEP];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] sent_q;
	logic [MAX_KEEP-1:0] sent_mask_q;

	logic [ID_W-1:0]  item_id_q;
	logic [DEG_W-1:0] item_deg_q;
	logic             item_last_q;

	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] min_idx_q;
	logic [DEG_W-1:0] min_deg_q;
	logic [ID_W-1:0]  min_id_q;
	logic             min_ok_q;

	logic [IDX_W-1:0] best_idx_q;
	logic [DEG_W-1:0] best_deg_q;
	logic [ID_W-1:0]  best_id_q;
	logic             best_found_q;

	logic             out_valid_q;
	logic [ID_W-1:0]  out_id_q;
	logic [DEG_W-1:0] out_deg_q;
	logic             out_last_q;

	logic [CNT_W-1:0] lim;
	logic [DEG_W-1:0] rd_deg;
	logic [ID_W-1:0]  rd_id;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             beats_min;
	logic             take_min;
	logic             take_max;

	assign lim       = eff_limit(top_count);
	assign rd_deg    = held_deg_q[scan_q];
	assign rd_id     = held_id_q[scan_q];
	assign beats_min = (item_deg_q > min_deg_q);
	assign take_min  = (scan_q == '0) || ranks_below(rd_deg, rd_id, min_deg_q, min_id_q);
	assign take_max  = !sent_mask_q[scan_q]
		&& (!best_found_q || ranks_below(best_deg_q, best_id_q, rd_deg, rd_id));

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = min_idx_q;
		if (cmd.append) begin
			wr_en  = 1'b1;
			wr_idx = count_q[IDX_W-1:0];
		end else if (cmd.replace && beats_min) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			held_deg_q[wr_idx] <= item_deg_q;
			held_id_q[wr_idx]  <= item_id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_id_q   <= in_id;
			item_deg_q  <= in_deg;
			item_last_q <= in_last;
		end
		if (cmd.min_step && take_min) begin
			min_idx_q <= scan_q;
			min_deg_q <= rd_deg;
			min_id_q  <= rd_id;
		end
		if (cmd.max_step && take_max) begin
			best_idx_q <= scan_q;
			best_deg_q <= rd_deg;
			best_id_q  <= rd_id;
		end
		if (cmd.load_out) begin
			out_id_q   <= best_id_q;
			out_deg_q  <= best_deg_q;
			out_last_q <= stat.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			sent_q       <= '0;
			sent_mask_q  <= '0;
			scan_q       <= '0;
			min_ok_q     <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.min_clear || cmd.max_clear) begin
				scan_q <= '0;
			end else if (cmd.min_step || cmd.max_step) begin
				scan_q <= scan_q + IDX_W'(1);
			end

			if (cmd.min_clear || cmd.append || (cmd.replace && beats_min) || cmd.clear_all) begin
				min_ok_q <= 1'b0;
			end else if (cmd.min_step && stat.scan_last) begin
				min_ok_q <= 1'b1;
			end

			if (cmd.clear_all) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (cmd.max_clear) begin
				best_found_q <= 1'b0;
			end else if (cmd.max_step && take_max) begin
				best_found_q <= 1'b1;
			end

			// The final result and the emptying of the store share one cycle.
			if (cmd.clear_all) begin
				sent_q      <= '0;
				sent_mask_q <= '0;
			end else if (cmd.load_out) begin
				sent_mask_q[best_idx_q] <= 1'b1;
				sent_q                  <= sent_q + CNT_W'(1);
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.full      = (count_q >= lim);
		stat.min_ok    = min_ok_q;
		stat.scan_last = (CNT_W'(scan_q) == count_q - CNT_W'(1));
		stat.item_last = item_last_q;
		stat.out_free  = !out_valid_q || out_ready;
		stat.emit_last = (sent_q + CNT_W'(1) == count_q);
	end

	assign out_valid = out_valid_q;
	assign out_id    = out_id_q;
	assign out_deg   = out_deg_q;
	assign out_last  = out_last_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_KEEP)
		else $error("held count above capacity");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (count_q < lim))
		else $error("append into a full store");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over an untaken result");
	a_min_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		min_ok_q |-> (CNT_W'(min_idx_q) < count_q))
		else $error("cached smallest entry outside the held range");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> (count_q == '0) && (sent_mask_q == '0))
		else $error("store not emptied after the final result");
`endif

endmodule

`default_nettype wire

/* hw/rtl/tkds_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tkds_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire tkds_pkg::tkds_stat_t stat,
	output tkds_pkg::tkds_cmd_t       cmd
);
	import tkds_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DECIDE   = 3'd1;
	localparam logic [2:0] ST_MINSCAN  = 3'd2;
	localparam logic [2:0] ST_MAXSTART = 3'd3;
	localparam logic [2:0] ST_MAXSCAN  = 3'd4;
	localparam logic [2:0] ST_EMIT     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!stat.full) begin
					cmd.append = 1'b1;
					state_d    = stat.item_last ? ST_MAXSTART : ST_IDLE;
				end else if (stat.min_ok) begin
					cmd.replace = 1'b1;
					state_d     = stat.item_last ? ST_MAXSTART : ST_IDLE;
				end else begin
					cmd.min_clear = 1'b1;
					state_d       = ST_MINSCAN;
				end
			end
			ST_MINSCAN: begin
				cmd.min_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_MAXSTART: begin
				cmd.max_clear = 1'b1;
				state_d       = ST_MAXSCAN;
			end
			ST_MAXSCAN: begin
				cmd.max_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					if (stat.emit_last) begin
						cmd.clear_all = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						state_d = ST_MAXSTART;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire
